### src/mst_pkg.sv
// mst_pkg: shared types and constants for the multi-slot timer table.
// Holds the request/response words, the slot entry layout and the codes.
// No dependencies.
package mst_pkg;

    localparam int TIME_BITS = 48;
    localparam int ID_BITS   = 32;
    localparam int KIND_BITS = 3;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_UPDATE = 2'd1,
        OP_REMOVE = 2'd2,
        OP_TICK   = 2'd3
    } opcode_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_ADDED   = 3'd0,
        KIND_UPDATED = 3'd1,
        KIND_REMOVED = 3'd2,
        KIND_FIRED   = 3'd3,
        KIND_SUMMARY = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_SEARCH,
        ST_TICK,
        ST_FOLD,
        ST_SUMMARY
    } state_t;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [TIME_BITS-1:0] now_time;
        logic [TIME_BITS-1:0] period;
        logic                 repeat_flag;
        logic                 enable_flag;
        logic [ID_BITS-1:0]   target_id;
    } req_t;

    typedef struct packed {
        logic [KIND_BITS-1:0] kind;
        logic [ID_BITS-1:0]   result_id;
        logic                 found;
        logic                 released;
        logic [TIME_BITS-1:0] next_deadline;
        logic                 deadline_valid;
        logic                 last;
    } rsp_t;

    typedef struct packed {
        logic [ID_BITS-1:0]   ident;
        logic [TIME_BITS-1:0] period;
        logic [TIME_BITS-1:0] deadline;
        logic                 repeats;
    } slot_t;

endpackage

### src/mst_slot_ram.sv
// mst_slot_ram: slot entry store, one write and one registered read port.
// Depends on mst_pkg for the entry layout.
module mst_slot_ram #(
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  mst_pkg::slot_t      wdata,
    input  logic                re,
    input  logic [ADDR_W-1:0]   raddr,
    output mst_pkg::slot_t      rdata
);
    import mst_pkg::*;

    slot_t mem [DEPTH];
    slot_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/mst_out_q.sv
// mst_out_q: two-word result queue between the sequencer and the rsp channel.
// Depends on mst_pkg for the result word.
module mst_out_q (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mst_pkg::rsp_t  push_word,
    output logic           space,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output mst_pkg::rsp_t  rsp
);
    import mst_pkg::*;

    rsp_t       fifo_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       pop;

    assign space     = (cnt_reg != 2'd2);
    assign rsp_valid = (cnt_reg != 2'd0);
    assign rsp       = fifo_reg[rd_ptr_reg];
    assign pop       = rsp_valid & rsp_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

### src/mst_ctrl.sv
// mst_ctrl: read-modify-write sequencer; one slot per cycle unless the queue is full.
// Depends on mst_pkg; drives mst_slot_ram and feeds mst_out_q.
module mst_ctrl #(
    parameter int TIMER_SLOTS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  mst_pkg::req_t        req,
    output logic                 mem_we,
    output logic [(TIMER_SLOTS > 1 ? $clog2(TIMER_SLOTS) : 1)-1:0] mem_waddr,
    output mst_pkg::slot_t       mem_wdata,
    output logic                 mem_re,
    output logic [(TIMER_SLOTS > 1 ? $clog2(TIMER_SLOTS) : 1)-1:0] mem_raddr,
    input  mst_pkg::slot_t       mem_rdata,
    output logic                 push,
    output mst_pkg::rsp_t        push_word,
    input  logic                 space
);
    import mst_pkg::*;

    localparam int ADDR_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W  = $clog2(TIMER_SLOTS + 1);

    function automatic logic [TIME_BITS-1:0] sat_add(
        input logic [TIME_BITS-1:0] a,
        input logic [TIME_BITS-1:0] b
    );
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

    state_t                 state_reg, state_next;
    req_t                   req_reg, req_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [ID_BITS-1:0]     id_ctr_reg, id_ctr_next;
    logic [TIMER_SLOTS-1:0] used_reg, used_next;
    logic [TIMER_SLOTS-1:0] en_reg, en_next;
    logic [TIME_BITS-1:0]   soonest_reg, soonest_next;
    logic                   have_reg, have_next;
    logic [TIME_BITS-1:0]   cand_reg, cand_next;
    logic                   cand_vld_reg, cand_vld_next;

    slot_t                  cur;
    logic [ADDR_W-1:0]      addr;
    logic                   is_last;
    logic                   used_i, en_i, act, fire, match, is_update;
    logic [TIME_BITS-1:0]   sum_sat;
    logic [ID_BITS-1:0]     id_inc;

    assign cur       = mem_rdata;
    assign addr      = idx_reg[ADDR_W-1:0];
    assign is_last   = (idx_reg == CNT_W'(TIMER_SLOTS - 1));
    assign used_i    = used_reg[addr];
    assign en_i      = en_reg[addr];
    assign act       = used_i & en_i;
    assign fire      = act & (cur.deadline <= req_reg.now_time);
    assign match     = used_i & (cur.ident == req_reg.target_id) & (req_reg.target_id != '0);
    assign is_update = (req_reg.opcode == OP_UPDATE);
    assign sum_sat   = sat_add(req_reg.now_time,
                               (state_reg == ST_TICK) ? cur.period : req_reg.period);
    assign id_inc    = id_ctr_reg + 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req.opcode)
                        OP_ADD:    state_next = ST_ADD;
                        OP_UPDATE: state_next = ST_SEARCH;
                        OP_REMOVE: state_next = ST_SEARCH;
                        default:   state_next = ST_TICK;
                    endcase
                end
            end
            ST_ADD:
            begin
                if ((!used_i || is_last) && space)
                    state_next = ST_IDLE;
            end
            ST_SEARCH:
            begin
                if ((match || is_last) && space)
                    state_next = ST_IDLE;
            end
            ST_TICK:
            begin
                if ((!fire || space) && is_last)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                state_next = ST_SUMMARY;
            end
            ST_SUMMARY:
            begin
                if (space)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        req_ready = 1'b0;
        mem_re    = 1'b0;
        mem_raddr = ADDR_W'(idx_reg + 1'b1);
        mem_we    = 1'b0;
        mem_waddr = addr;
        mem_wdata = cur;
        push      = 1'b0;
        push_word = '0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                mem_re    = 1'b1;
                mem_raddr = '0;
            end
            ST_ADD:
            begin
                mem_wdata.ident    = id_ctr_reg;
                mem_wdata.period   = req_reg.period;
                mem_wdata.deadline = sum_sat;
                mem_wdata.repeats  = req_reg.repeat_flag;
                if (!used_i || is_last)
                begin
                    push                = space;
                    push_word.kind      = KIND_ADDED;
                    push_word.result_id = used_i ? '0 : id_ctr_reg;
                    push_word.last      = 1'b1;
                    mem_we              = space & !used_i;
                end
            end
            ST_SEARCH:
            begin
                mem_wdata.period   = req_reg.period;
                mem_wdata.deadline = sum_sat;
                if (match || is_last)
                begin
                    push                = space;
                    push_word.kind      = is_update ? KIND_UPDATED : KIND_REMOVED;
                    push_word.result_id = req_reg.target_id;
                    push_word.found     = match;
                    push_word.last      = 1'b1;
                    mem_we              = space & match & is_update;
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end
            ST_TICK:
            begin
                mem_wdata.deadline = sum_sat;
                if (fire)
                begin
                    push                = space;
                    push_word.kind      = KIND_FIRED;
                    push_word.result_id = cur.ident;
                    push_word.released  = !cur.repeats;
                    mem_we              = space & cur.repeats;
                end
                mem_re = (!fire || space) && !is_last;
            end
            ST_SUMMARY:
            begin
                push                     = space;
                push_word.kind           = KIND_SUMMARY;
                push_word.next_deadline  = have_reg ? soonest_reg : '0;
                push_word.deadline_valid = have_reg;
                push_word.last           = 1'b1;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    // request capture, slot index, slot flags, id counter, earliest-deadline tracking
    always_comb
    begin
        req_next      = req_reg;
        idx_next      = idx_reg;
        id_ctr_next   = id_ctr_reg;
        used_next     = used_reg;
        en_next       = en_reg;
        soonest_next  = soonest_reg;
        have_next     = have_reg;
        cand_next     = cand_reg;
        cand_vld_next = 1'b0;
        if (cand_vld_reg && (!have_reg || cand_reg < soonest_reg))
        begin
            soonest_next = cand_reg;
            have_next    = 1'b1;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next  = req;
                    idx_next  = '0;
                    have_next = 1'b0;
                end
            end
            ST_ADD:
            begin
                if (!used_i)
                begin
                    if (space)
                    begin
                        used_next[addr] = 1'b1;
                        en_next[addr]   = 1'b1;
                        id_ctr_next     = (id_inc == '0) ? ID_BITS'(1) : id_inc;
                    end
                end
                else if (!is_last)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SEARCH:
            begin
                if (match)
                begin
                    if (space)
                    begin
                        if (is_update)
                        begin
                            en_next[addr] = req_reg.enable_flag;
                        end
                        else
                        begin
                            used_next[addr] = 1'b0;
                            en_next[addr]   = 1'b0;
                        end
                    end
                end
                else if (!is_last)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_TICK:
            begin
                if (!fire || space)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (fire && !cur.repeats)
                    begin
                        used_next[addr] = 1'b0;
                        en_next[addr]   = 1'b0;
                    end
                    cand_vld_next = act & (!fire | cur.repeats);
                    cand_next     = fire ? sum_sat : cur.deadline;
                end
            end
            default:
            begin
                idx_next = idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            id_ctr_reg   <= ID_BITS'(1);
            used_reg     <= '0;
            en_reg       <= '0;
            have_reg     <= 1'b0;
            cand_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            id_ctr_reg   <= id_ctr_next;
            used_reg     <= used_next;
            en_reg       <= en_next;
            have_reg     <= have_next;
            cand_vld_reg <= cand_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg     <= req_next;
        soonest_reg <= soonest_next;
        cand_reg    <= cand_next;
    end

endmodule

### src/multi_slot_timer_table.sv
// multi_slot_timer_table: top level of the timer slot table.
// Depends on mst_pkg, mst_slot_ram, mst_out_q and mst_ctrl.
//
// One request word is taken at a time and the next is accepted once its last
// result word has been queued. Slot entries live in a single RAM with one
// registered read port and the sequencer visits one slot per cycle, pausing
// only while a result word waits for room in the full two-word result queue:
// an add scans up to the first free slot, an update or remove up to the
// matching slot and a tick every slot, followed by a fold step and a summary
// word. Used and enabled flags are flip-flops cleared by reset, so no clearing
// pass is needed.
module multi_slot_timer_table #(
    parameter int TIMER_SLOTS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  mst_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output mst_pkg::rsp_t  rsp
);
    import mst_pkg::*;

    localparam int ADDR_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;

    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    slot_t             mem_wdata, mem_rdata;
    logic              push, space;
    rsp_t              push_word;

    mst_slot_ram #(
        .DEPTH  (TIMER_SLOTS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    mst_ctrl #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .push      (push),
        .push_word (push_word),
        .space     (space)
    );

    mst_out_q u_out_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .space     (space),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
